// ===== sv/ers_pkg.sv =====
`timescale 1ns / 1ps

package ers_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RESULT = 2'd1;
    localparam logic [1:0] OP_ABORT = 2'd2;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_STEP1 = 3'd1;
    localparam logic [2:0] PH_STEP2 = 3'd2;
    localparam logic [2:0] PH_STEP3 = 3'd3;
    localparam logic [2:0] PH_SUCCESS = 3'd4;
    localparam logic [2:0] PH_ERROR = 3'd5;

    localparam logic [3:0] OC_NONE = 4'd0;
    localparam logic [3:0] OC_SUCCESS = 4'd1;
    localparam logic [3:0] OC_BAD_ARG = 4'd8;
    localparam logic [3:0] OC_FAILED = 4'd9;
    localparam logic [3:0] OC_BUSY = 4'd10;

    localparam logic [3:0] SO_OK = 4'd0;
    localparam logic [3:0] SO_IO_LAST = 4'd7;
    localparam logic [3:0] SO_FAILED = 4'd8;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_NEXT = 3'd1;
    localparam logic [2:0] ACT_RETRY = 3'd2;
    localparam logic [2:0] ACT_COMPLETE = 3'd3;
    localparam logic [2:0] ACT_FAIL = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    localparam logic [2:0] CFG_MAX_RETRIES_FIRST = 3'd0;
    localparam logic [2:0] CFG_MAX_RETRIES_SECOND = 3'd1;
    localparam logic [2:0] CFG_MAX_RETRIES_THIRD = 3'd2;
    localparam logic [2:0] CFG_USER_ID_LOWEST = 3'd3;
    localparam logic [2:0] CFG_USER_ID_HIGHEST = 3'd4;

    localparam logic [7:0] PERM_MIN = 8'd1;
    localparam logic [7:0] PERM_MAX = 8'd3;
    localparam logic [1:0] STEPS_MAX = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] user_number;
        logic [7:0]  access_level;
        logic [3:0]  sensor_outcome;
    } ers_in_t;

    typedef struct packed {
        logic [2:0]  next_action;
        logic [1:0]  start_status;
        logic [1:0]  step_command;
        logic [15:0] user_out;
        logic [1:0]  permission_out;
        logic [7:0]  retry_number;
        logic [3:0]  outcome_code;
        logic [2:0]  phase;
        logic [1:0]  steps_done;
    } ers_out_t;

    typedef struct packed {
        logic [7:0]  max_retries_first;
        logic [7:0]  max_retries_second;
        logic [15:0] user_id_lowest;
        logic [15:0] user_id_highest;
    } ers_cfg_t;

endpackage

// ===== sv/ers_cfg_regs.sv =====
`timescale 1ns / 1ps

module ers_cfg_regs
    import ers_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output ers_cfg_t    cfg
);

    ers_cfg_t cfg_reg;
    ers_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_RETRIES_FIRST:  cfg_next.max_retries_first = cfg_data[7:0];
                CFG_MAX_RETRIES_SECOND: cfg_next.max_retries_second = cfg_data[7:0];
                CFG_MAX_RETRIES_THIRD:  cfg_next = cfg_reg;
                CFG_USER_ID_LOWEST:     cfg_next.user_id_lowest = cfg_data;
                CFG_USER_ID_HIGHEST:    cfg_next.user_id_highest = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_retries_first <= 8'd3;
            cfg_reg.max_retries_second <= 8'd3;
            cfg_reg.user_id_lowest <= 16'd1;
            cfg_reg.user_id_highest <= 16'hFFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/enrollment_retry_sequencer_top.sv =====
`timescale 1ns / 1ps

// Enrollment sequencer: each event item is latched into an input register and then,
// once the result register can take it, evaluated against the phase, retry and user
// state in combinational logic that writes the new state and the result register.
// One item per clock is sustained while result_stall is low; the result register
// loads when the latched item is evaluated, and the state update at that same edge
// is what sets that rate. Retry limits and user id range come from the configuration
// port, which accepts a write in every cycle.
module enrollment_retry_sequencer_top
    import ers_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  ers_in_t     item,
    output logic        result_valid,
    input  logic        result_stall,
    output ers_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ers_cfg_t cfg;

    logic     s1_valid_reg;
    ers_in_t  s1_item_reg;
    logic     out_valid_reg;
    ers_out_t out_item_reg;
    ers_out_t out_item_next;
    logic     out_advance;
    logic     fire;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  outcome_reg, outcome_next;
    logic [15:0] user_reg, user_next;
    logic [1:0]  permission_reg, permission_next;
    logic [1:0]  steps_done_reg, steps_done_next;
    logic [7:0]  retry_first_reg, retry_first_next;
    logic [7:0]  retry_second_reg, retry_second_next;

    logic        active;
    logic [7:0]  retry_cur;
    logic [7:0]  retry_lim;
    logic [7:0]  retry_inc;

    ers_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_advance = !out_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !out_advance;
    assign fire = s1_valid_reg && out_advance;
    assign result_valid = out_valid_reg;
    assign result = out_item_reg;

    assign active = (phase_reg == PH_STEP1) || (phase_reg == PH_STEP2)
                    || (phase_reg == PH_STEP3);
    assign retry_cur = (phase_reg == PH_STEP1) ? retry_first_reg : retry_second_reg;
    assign retry_lim = (phase_reg == PH_STEP1) ? cfg.max_retries_first
                                               : cfg.max_retries_second;
    assign retry_inc = retry_cur + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        outcome_next = outcome_reg;
        user_next = user_reg;
        permission_next = permission_reg;
        steps_done_next = steps_done_reg;
        retry_first_next = retry_first_reg;
        retry_second_next = retry_second_reg;
        out_item_next = '0;

        case (s1_item_reg.operation)
            OP_START:
            begin
                if (active)
                begin
                    outcome_next = OC_BUSY;
                    out_item_next.start_status = ST_BUSY;
                end
                else if (s1_item_reg.user_number < cfg.user_id_lowest
                         || s1_item_reg.user_number > cfg.user_id_highest
                         || s1_item_reg.access_level < PERM_MIN
                         || s1_item_reg.access_level > PERM_MAX)
                begin
                    outcome_next = OC_BAD_ARG;
                    out_item_next.start_status = ST_INVALID;
                end
                else
                begin
                    phase_next = PH_STEP1;
                    outcome_next = OC_NONE;
                    user_next = s1_item_reg.user_number;
                    permission_next = s1_item_reg.access_level[1:0];
                    steps_done_next = 2'd0;
                    retry_first_next = 8'd0;
                    retry_second_next = 8'd0;
                end
            end
            OP_RESULT:
            begin
                if (active)
                begin
                    out_item_next.user_out = user_reg;
                    out_item_next.permission_out = permission_reg;
                    if (s1_item_reg.sensor_outcome == SO_OK)
                    begin
                        if (steps_done_reg != STEPS_MAX)
                        begin
                            steps_done_next = steps_done_reg + 2'd1;
                        end
                        if (phase_reg == PH_STEP3)
                        begin
                            phase_next = PH_SUCCESS;
                            outcome_next = OC_SUCCESS;
                            out_item_next.next_action = ACT_COMPLETE;
                        end
                        else
                        begin
                            phase_next = phase_reg + 3'd1;
                            outcome_next = OC_NONE;
                            out_item_next.next_action = ACT_NEXT;
                            out_item_next.step_command = phase_next[1:0];
                        end
                    end
                    else if (s1_item_reg.sensor_outcome == SO_FAILED
                             && phase_reg != PH_STEP3 && retry_cur < retry_lim)
                    begin
                        if (phase_reg == PH_STEP1)
                        begin
                            retry_first_next = retry_inc;
                        end
                        else
                        begin
                            retry_second_next = retry_inc;
                        end
                        out_item_next.next_action = ACT_RETRY;
                        out_item_next.step_command = phase_reg[1:0];
                        out_item_next.retry_number = retry_inc;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        outcome_next = (s1_item_reg.sensor_outcome <= SO_IO_LAST)
                                       ? s1_item_reg.sensor_outcome + 4'd1 : OC_FAILED;
                        out_item_next.next_action = ACT_FAIL;
                    end
                end
            end
            OP_ABORT:
            begin
                phase_next = PH_IDLE;
                outcome_next = OC_NONE;
                user_next = 16'd0;
                permission_next = 2'd0;
                steps_done_next = 2'd0;
                retry_first_next = 8'd0;
                retry_second_next = 8'd0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        out_item_next.outcome_code = outcome_next;
        out_item_next.phase = phase_next;
        out_item_next.steps_done = steps_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg <= PH_IDLE;
            outcome_reg <= OC_NONE;
            user_reg <= 16'd0;
            permission_reg <= 2'd0;
            steps_done_reg <= 2'd0;
            retry_first_reg <= 8'd0;
            retry_second_reg <= 8'd0;
        end
        else
        begin
            if (out_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (!item_stall)
            begin
                s1_valid_reg <= item_valid;
            end
            if (fire)
            begin
                phase_reg <= phase_next;
                outcome_reg <= outcome_next;
                user_reg <= user_next;
                permission_reg <= permission_next;
                steps_done_reg <= steps_done_next;
                retry_first_reg <= retry_first_next;
                retry_second_reg <= retry_second_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_item_reg <= item;
        end
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // idle is only ever entered through a full clear
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> steps_done_reg == 2'd0 && user_reg == 16'd0)
        else $error("idle phase with leftover enrollment state");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SUCCESS |-> steps_done_reg == STEPS_MAX)
        else $error("success reached without three steps");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && out_valid_reg && result_stall)
        else $error("input stalled while pipeline can move");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.next_action == ACT_RETRY
        |-> out_item_reg.retry_number != 8'd0 && out_item_reg.step_command != 2'd0)
        else $error("retry result without count or step");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("evaluated item lost before result register");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ers_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [3:0] SO_UNDEFINED = 4'd15;
    localparam logic [2:0] CFG_UNMAPPED = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    ers_in_t     item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    ers_out_t    result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    ers_in_t  event_queue[$];
    ers_out_t predicted_responses[$];
    bit       idle_on = 1'b0;
    int       failures = 0;

    // predicted sequencer state and registers
    logic [2:0]  seq_phase;
    logic [3:0]  seq_outcome;
    logic [15:0] seq_user;
    logic [1:0]  seq_perm;
    logic [1:0]  seq_steps;
    logic [7:0]  seq_retries[3];
    logic [7:0]  lim_first = 8'd3;
    logic [7:0]  lim_second = 8'd3;
    logic [15:0] uid_low = 16'd1;
    logic [15:0] uid_high = 16'hFFFF;

    enrollment_retry_sequencer_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void clear_session();
        seq_phase = PH_IDLE;
        seq_outcome = OC_NONE;
        seq_user = '0;
        seq_perm = '0;
        seq_steps = '0;
        for (int i = 0; i < 3; i++)
        begin
            seq_retries[i] = '0;
        end
    endfunction

    function automatic ers_out_t sequence_event(input ers_in_t ev);
        ers_out_t r;
        logic [7:0] lim;
        int idx;
        bit active;
        bit retried;
        r = '0;
        active = (seq_phase >= PH_STEP1) && (seq_phase <= PH_STEP3);
        case (ev.operation)
            OP_START:
            begin
                if (active)
                begin
                    seq_outcome = OC_BUSY;
                    r.start_status = ST_BUSY;
                end
                else if (ev.user_number < uid_low || ev.user_number > uid_high ||
                         ev.access_level < PERM_MIN || ev.access_level > PERM_MAX)
                begin
                    seq_outcome = OC_BAD_ARG;
                    r.start_status = ST_INVALID;
                end
                else
                begin
                    clear_session();
                    seq_phase = PH_STEP1;
                    seq_user = ev.user_number;
                    seq_perm = ev.access_level[1:0];
                end
            end
            OP_RESULT:
            begin
                if (active)
                begin
                    r.user_out = seq_user;
                    r.permission_out = seq_perm;
                    if (ev.sensor_outcome == SO_OK)
                    begin
                        if (seq_steps < STEPS_MAX)
                            seq_steps = seq_steps + 2'd1;
                        if (seq_phase == PH_STEP1 || seq_phase == PH_STEP2)
                        begin
                            seq_phase = seq_phase + 3'd1;
                            seq_outcome = OC_NONE;
                            r.next_action = ACT_NEXT;
                            r.step_command = seq_phase[1:0];
                        end
                        else
                        begin
                            seq_phase = PH_SUCCESS;
                            seq_outcome = OC_SUCCESS;
                            r.next_action = ACT_COMPLETE;
                        end
                    end
                    else
                    begin
                        retried = 1'b0;
                        if (ev.sensor_outcome == SO_FAILED && seq_phase != PH_STEP3)
                        begin
                            idx = int'(seq_phase) - 1;
                            lim = (seq_phase == PH_STEP1) ? lim_first : lim_second;
                            if (seq_retries[idx] < lim)
                            begin
                                seq_retries[idx] = seq_retries[idx] + 8'd1;
                                r.next_action = ACT_RETRY;
                                r.step_command = seq_phase[1:0];
                                r.retry_number = seq_retries[idx];
                                retried = 1'b1;
                            end
                        end
                        if (!retried)
                        begin
                            seq_phase = PH_ERROR;
                            seq_outcome = (ev.sensor_outcome <= SO_IO_LAST) ?
                                          ev.sensor_outcome + 4'd1 : OC_FAILED;
                            r.next_action = ACT_FAIL;
                        end
                    end
                end
            end
            OP_ABORT:
            begin
                clear_session();
            end
            default:
            begin
            end
        endcase
        r.outcome_code = seq_outcome;
        r.phase = seq_phase;
        r.steps_done = seq_steps;
        return r;
    endfunction

    function automatic ers_in_t mk_event(input logic [1:0] op, input logic [15:0] uid,
                                         input logic [7:0] perm, input logic [3:0] so);
        ers_in_t ev;
        ev.operation = op;
        ev.user_number = uid;
        ev.access_level = perm;
        ev.sensor_outcome = so;
        return ev;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin : driver
        int send_gap;
        bit fire;
        if (rst_n)
        begin
            fire = item_valid && !item_stall;
            if (fire)
                predicted_responses.push_back(sequence_event(item));
            if (!item_valid || fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (event_queue.size() > 0)
                begin
                    item <= event_queue.pop_front();
                    item_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 10);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
        else
        begin
            send_gap = 0;
            item_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        ers_out_t want;
        int results_seen;
        int hold_left;
        int stall_left;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_responses.size() == 0)
                begin
                    $error("result with no item pending");
                    failures++;
                end
                else
                begin
                    want = predicted_responses.pop_front();
                    compare_field("next_action", want.next_action, result.next_action);
                    compare_field("start_status", want.start_status, result.start_status);
                    compare_field("step_command", want.step_command, result.step_command);
                    compare_field("user_out", want.user_out, result.user_out);
                    compare_field("permission_out", want.permission_out,
                                  result.permission_out);
                    compare_field("retry_number", want.retry_number, result.retry_number);
                    compare_field("outcome_code", want.outcome_code, result.outcome_code);
                    compare_field("phase", want.phase, result.phase);
                    compare_field("steps_done", want.steps_done, result.steps_done);
                end
                results_seen++;
                // long hold-off so the block backs up into its input
                if (results_seen == 120 || results_seen == 420)
                    hold_left = 60;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
        else
        begin
            results_seen = 0;
            hold_left = 0;
            stall_left = 0;
            result_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MAX_RETRIES_FIRST: lim_first = val[7:0];
            CFG_MAX_RETRIES_SECOND: lim_second = val[7:0];
            CFG_USER_ID_LOWEST: uid_low = val;
            CFG_USER_ID_HIGHEST: uid_high = val;
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        while (event_queue.size() != 0 || item_valid || predicted_responses.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [3:0] pick_outcome();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return SO_OK;
        else if (r < 17)
            return SO_FAILED;
        return 4'($urandom_range(0, 15));
    endfunction

    // mostly complete enrollments with random content, the rest noise
    task automatic queue_sessions(input int count);
        int pushed;
        int steps;
        logic [15:0] uid;
        pushed = 0;
        while (pushed < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if (uid_low <= uid_high && $urandom_range(0, 9) != 0)
                    uid = 16'($urandom_range(int'(uid_high), int'(uid_low)));
                else
                    uid = 16'($urandom);
                event_queue.push_back(mk_event(OP_START, uid,
                                               8'($urandom_range(PERM_MIN, PERM_MAX)),
                                               4'($urandom)));
                pushed++;
                steps = $urandom_range(2, 10);
                for (int i = 0; i < steps; i++)
                begin
                    if ($urandom_range(0, 14) == 0)
                    begin
                        event_queue.push_back(mk_event(OP_ABORT, 16'($urandom),
                                                       8'($urandom), 4'($urandom)));
                        pushed++;
                        break;
                    end
                    event_queue.push_back(mk_event(OP_RESULT, 16'($urandom), 8'($urandom),
                                                   pick_outcome()));
                    pushed++;
                end
            end
            else
            begin
                event_queue.push_back(mk_event(2'($urandom), 16'($urandom), 8'($urandom),
                                               4'($urandom)));
                pushed++;
            end
        end
    endtask

    initial
    begin
        clear_session();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        idle_on = 1'b1;
        @(negedge clk);

        // directed: ignored events, start checks, retry limits, each ending
        event_queue.push_back(mk_event(OP_RESULT, 16'h0000, 8'h00, SO_OK));
        event_queue.push_back(mk_event(OP_UNUSED, 16'hFFFF, 8'hFF, SO_UNDEFINED));
        event_queue.push_back(mk_event(OP_START, 16'h0000, PERM_MIN, SO_OK));
        event_queue.push_back(mk_event(OP_START, 16'h0001, 8'h00, SO_OK));
        event_queue.push_back(mk_event(OP_START, 16'h0001, 8'h04, SO_OK));
        event_queue.push_back(mk_event(OP_START, 16'hFFFF, 8'hFF, SO_UNDEFINED));
        event_queue.push_back(mk_event(OP_START, 16'hFFFF, PERM_MAX, SO_OK));
        event_queue.push_back(mk_event(OP_START, 16'h0001, PERM_MIN, SO_OK));
        repeat (4) event_queue.push_back(mk_event(OP_RESULT, 16'h0000, 8'h00, SO_FAILED));
        event_queue.push_back(mk_event(OP_START, 16'h0001, PERM_MIN, SO_OK));
        event_queue.push_back(mk_event(OP_RESULT, 16'hFFFF, 8'hFF, SO_OK));
        event_queue.push_back(mk_event(OP_RESULT, 16'h0000, 8'h00, SO_FAILED));
        event_queue.push_back(mk_event(OP_RESULT, 16'h0000, 8'h00, SO_OK));
        event_queue.push_back(mk_event(OP_RESULT, 16'h0000, 8'h00, SO_FAILED));
        event_queue.push_back(mk_event(OP_START, 16'h8000, 8'h02, SO_OK));
        repeat (3) event_queue.push_back(mk_event(OP_RESULT, 16'h0000, 8'h00, SO_OK));
        event_queue.push_back(mk_event(OP_RESULT, 16'h0000, 8'h00, SO_OK));
        event_queue.push_back(mk_event(OP_START, 16'h1234, 8'h02, SO_OK));
        event_queue.push_back(mk_event(OP_RESULT, 16'h0000, 8'h00, SO_UNDEFINED));
        event_queue.push_back(mk_event(OP_START, 16'h4321, PERM_MAX, SO_OK));
        event_queue.push_back(mk_event(OP_ABORT, 16'hFFFF, 8'hFF, SO_UNDEFINED));
        settle();

        write_reg(CFG_MAX_RETRIES_FIRST, 16'h0000);
        write_reg(CFG_MAX_RETRIES_SECOND, 16'hFFFF);
        write_reg(CFG_MAX_RETRIES_THIRD, 16'hFFFF);
        write_reg(CFG_USER_ID_LOWEST, 16'h0000);
        write_reg(CFG_USER_ID_HIGHEST, 16'h0000);
        queue_sessions(110);
        settle();

        write_reg(CFG_MAX_RETRIES_FIRST, 16'h0002);
        write_reg(CFG_MAX_RETRIES_SECOND, 16'h0001);
        write_reg(CFG_MAX_RETRIES_THIRD, 16'h005A);
        write_reg(CFG_USER_ID_LOWEST, 16'h0100);
        write_reg(CFG_USER_ID_HIGHEST, 16'hFFFF);
        write_reg(CFG_UNMAPPED, 16'h1234);
        queue_sessions(110);
        settle();

        // empty user id range: every start is rejected
        write_reg(CFG_MAX_RETRIES_FIRST, 16'h0001);
        write_reg(CFG_MAX_RETRIES_SECOND, 16'h0000);
        write_reg(CFG_USER_ID_LOWEST, 16'hFFFF);
        write_reg(CFG_USER_ID_HIGHEST, 16'h0000);
        queue_sessions(110);
        settle();

        write_reg(CFG_MAX_RETRIES_FIRST, 16'h0005);
        write_reg(CFG_MAX_RETRIES_SECOND, 16'h0004);
        write_reg(CFG_USER_ID_LOWEST, 16'h1000);
        write_reg(CFG_USER_ID_HIGHEST, 16'h2000);
        queue_sessions(110);
        settle();

        write_reg(CFG_MAX_RETRIES_FIRST, 16'h0003);
        write_reg(CFG_MAX_RETRIES_SECOND, 16'h0003);
        write_reg(CFG_MAX_RETRIES_THIRD, 16'h0000);
        write_reg(CFG_USER_ID_LOWEST, 16'h0001);
        write_reg(CFG_USER_ID_HIGHEST, 16'hFFFF);
        idle_on = 1'b0;
        queue_sessions(110);
        settle();

        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

endmodule
